[design/bve_pkg.sv]
package bve_pkg;

  // vector geometry
  localparam int NUM_BITS  = 64;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;

  // field widths
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SEL_W   = 1;
  localparam int DATA_W  = 32;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TEST      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUT_BIT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUT_RANGE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_OR_WORD   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_XOR_WORD  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_ENUM      = 3'd6;
  localparam logic [REQ_W-1:0] REQ_NOP       = 3'd7;

  // decoded command handed from front to back
  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [IDX_W-1:0]  index;
    logic              value;
    logic [CNT_W-1:0]  count;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

[design/bve_front.sv]
module bve_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bve_pkg::REQ_W-1:0]  req_type,
  input  logic [bve_pkg::IDX_W-1:0]  bit_pos,
  input  logic                       bit_value,
  input  logic [bve_pkg::CNT_W-1:0]  range_count,
  input  logic [bve_pkg::SEL_W-1:0]  word_select,
  input  logic [bve_pkg::DATA_W-1:0] word_data,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output bve_pkg::cmd_t              cmd
);
  import bve_pkg::*;

  cmd_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] q_count;
  cmd_t               dec;
  logic               push;
  logic               pop;

  // classify the incoming item
  always_comb begin
    dec.index = bit_pos;
    dec.value = bit_value;
    dec.sel   = word_select;
    dec.data  = word_data;
    if (32'(range_count) > NUM_BITS) begin
      dec.count = CNT_W'(NUM_BITS);
    end else begin
      dec.count = range_count;
    end
    case (req_type)
      REQ_TEST, REQ_PUT_BIT, REQ_PUT_RANGE, REQ_CLEAR,
      REQ_OR_WORD, REQ_XOR_WORD, REQ_ENUM: dec.op = req_type;
      default: dec.op = REQ_NOP;
    endcase
  end

  assign in_ready  = (q_count != Q_CNT_W'(Q_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (q_count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_mem[rd_ptr];

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

[design/bve_back.sv]
module bve_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  bve_pkg::cmd_t             cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      test_bit,
  output logic [bve_pkg::IDX_W-1:0] bit_number,
  output logic                      found,
  output logic                      last
);
  import bve_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state;
  logic                state_next;
  logic [NUM_BITS-1:0] bit_store;
  logic [NUM_BITS-1:0] bit_store_next;
  logic [NUM_BITS-1:0] scan_rest;
  logic [NUM_BITS-1:0] scan_rest_next;
  logic [NUM_BITS-1:0] lowest;
  logic [NUM_BITS-1:0] range_mask;
  logic [NUM_BITS-1:0] word_mask;
  logic [IDX_W-1:0]    low_num;
  logic                can_load;
  logic                load;
  logic                res_test;
  logic [IDX_W-1:0]    res_num;
  logic                res_found;
  logic                res_last;
  logic                idx_ok;

  assign can_load = !out_valid || out_ready;
  assign idx_ok   = (32'(cmd.index) < NUM_BITS);

  // lowest remaining set bit and its number
  assign lowest = scan_rest & (~scan_rest + NUM_BITS'(1));
  always_comb begin
    low_num = '0;
    for (int i = 0; i < NUM_BITS; i++) begin
      if (lowest[i]) begin
        low_num = low_num | IDX_W'(i);
      end
    end
  end

  // masks for range and word requests
  always_comb begin
    for (int i = 0; i < NUM_BITS; i++) begin
      range_mask[i] = (32'(i) < 32'(cmd.count));
      word_mask[i]  = ((32'(i) / WORD_BITS) == 32'(cmd.sel)) &&
                      cmd.data[i % WORD_BITS];
    end
  end

  // execute commands and walk enumeration
  always_comb begin
    state_next     = state;
    bit_store_next = bit_store;
    scan_rest_next = scan_rest;
    cmd_ready      = 1'b0;
    load           = 1'b0;
    res_test       = 1'b0;
    res_num        = '0;
    res_found      = 1'b0;
    res_last       = 1'b1;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && can_load) begin
          cmd_ready = 1'b1;
          load      = 1'b1;
          case (cmd.op)
            REQ_TEST: begin
              res_test = idx_ok && bit_store[cmd.index];
            end
            REQ_PUT_BIT: begin
              if (idx_ok) begin
                bit_store_next[cmd.index] = cmd.value;
              end
            end
            REQ_PUT_RANGE: begin
              if (cmd.value) begin
                bit_store_next = bit_store | range_mask;
              end else begin
                bit_store_next = bit_store & ~range_mask;
              end
            end
            REQ_CLEAR: begin
              bit_store_next = '0;
            end
            REQ_OR_WORD: begin
              bit_store_next = bit_store | word_mask;
            end
            REQ_XOR_WORD: begin
              bit_store_next = bit_store ^ word_mask;
            end
            REQ_ENUM: begin
              if (bit_store != '0) begin
                load           = 1'b0;
                scan_rest_next = bit_store;
                state_next     = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (can_load) begin
          load           = 1'b1;
          res_num        = low_num;
          res_found      = 1'b1;
          scan_rest_next = scan_rest & ~lowest;
          res_last       = (scan_rest_next == '0);
          if (res_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state and bit store
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_store <= '0;
      scan_rest <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_store <= bit_store_next;
      scan_rest <= scan_rest_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      test_bit   <= res_test;
      bit_number <= res_num;
      found      <= res_found;
      last       <= res_last;
    end
  end

endmodule

[design/bit_vector_engine_top.sv]
// bit vector engine: 64-bit store with test, update and set-bit enumeration
// flow: an accepted item is written into the command queue, then executed by the
// back end, which registers its result in the result register
// throughput: one item per cycle for all requests but enumerate, while out_ready is high
// enumerate: enters the scan state when any bit is set, then gives one result per
// set bit; reset clears the bit store and the command queue and drops any result
module bit_vector_engine_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bve_pkg::REQ_W-1:0]  req_type,
  input  logic [bve_pkg::IDX_W-1:0]  bit_pos,
  input  logic                       bit_value,
  input  logic [bve_pkg::CNT_W-1:0]  range_count,
  input  logic [bve_pkg::SEL_W-1:0]  word_select,
  input  logic [bve_pkg::DATA_W-1:0] word_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       test_bit,
  output logic [bve_pkg::IDX_W-1:0]  bit_number,
  output logic                       found,
  output logic                       last
);
  import bve_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // accept and classify items
  bve_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .bit_pos     (bit_pos),
    .bit_value   (bit_value),
    .range_count (range_count),
    .word_select (word_select),
    .word_data   (word_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  // execute against the bit store
  bve_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .test_bit   (test_bit),
    .bit_number (bit_number),
    .found      (found),
    .last       (last)
  );

endmodule

[sim/bit_vector_engine_checker.sv]
`timescale 1ns / 100ps

module bit_vector_engine_checker
  import bve_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [IDX_W-1:0]  bit_pos,
  input  logic              bit_value,
  input  logic [CNT_W-1:0]  range_count,
  input  logic [SEL_W-1:0]  word_select,
  input  logic [DATA_W-1:0] word_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              test_bit,
  input  logic [IDX_W-1:0]  bit_number,
  input  logic              found,
  input  logic              last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic             test_bit;
    logic [IDX_W-1:0] bit_number;
    logic             found;
    logic             last;
  } bv_result_t;

  // shadow copy of the bit vector and the results still owed by the block
  logic [NUM_BITS-1:0] shadow_bits;
  bv_result_t          owed_results[$];

  // apply one accepted item to the shadow vector and queue what it yields
  task automatic apply_request(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic val, input logic [CNT_W-1:0] cnt,
                               input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] data);
    bv_result_t res;
    int         span;
    int         hits;
    res = '0;
    res.last = 1'b1;
    case (op)
      REQ_TEST: begin
        res.test_bit = shadow_bits[idx];
        owed_results.push_back(res);
      end
      REQ_PUT_BIT: begin
        shadow_bits[idx] = val;
        owed_results.push_back(res);
      end
      REQ_PUT_RANGE: begin
        // count saturates at the vector size
        span = (cnt > NUM_BITS) ? NUM_BITS : int'(cnt);
        for (int k = 0; k < span; k++) shadow_bits[k] = val;
        owed_results.push_back(res);
      end
      REQ_CLEAR: begin
        shadow_bits = '0;
        owed_results.push_back(res);
      end
      REQ_OR_WORD: begin
        shadow_bits[sel*WORD_BITS +: WORD_BITS] |= data;
        owed_results.push_back(res);
      end
      REQ_XOR_WORD: begin
        shadow_bits[sel*WORD_BITS +: WORD_BITS] ^= data;
        owed_results.push_back(res);
      end
      REQ_ENUM: begin
        // one result per set bit, ascending, last flag on the final one
        hits = 0;
        for (int k = 0; k < NUM_BITS; k++) begin
          if (shadow_bits[k]) begin
            res = '0;
            res.bit_number = k[IDX_W-1:0];
            res.found = 1'b1;
            owed_results.push_back(res);
            hits++;
          end
        end
        if (hits == 0) begin
          res = '0;
          res.last = 1'b1;
          owed_results.push_back(res);
        end else begin
          owed_results[owed_results.size()-1].last = 1'b1;
        end
      end
      default: begin
        owed_results.push_back(res);
      end
    endcase
  endtask

  // watch both channels; predict on input items, compare on output items
  always @(posedge clk) begin
    bv_result_t want;
    if (rst) begin
      shadow_bits = '0;
      owed_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        apply_request(req_type, bit_pos, bit_value, range_count, word_select, word_data);
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: bit_number %0d found %0d last %0d",
                 bit_number, found, last);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (test_bit !== want.test_bit) begin
            $error("test_bit mismatch: expected %0d, actual %0d", want.test_bit, test_bit);
            fail_count++;
          end
          if (bit_number !== want.bit_number) begin
            $error("bit_number mismatch: expected %0d, actual %0d",
                   want.bit_number, bit_number);
            fail_count++;
          end
          if (found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, found);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, last);
            fail_count++;
          end
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

[sim/bit_vector_engine_top_tb.sv]
`timescale 1ns / 100ps

module bit_vector_engine_top_tb;
  import bve_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  bit_pos;
  logic              bit_value;
  logic [CNT_W-1:0]  range_count;
  logic [SEL_W-1:0]  word_select;
  logic [DATA_W-1:0] word_data;
  logic              out_valid;
  logic              out_ready;
  logic              test_bit;
  logic [IDX_W-1:0]  bit_number;
  logic              found;
  logic              last;

  int fail_count;
  int pending;
  int items_accepted;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_req;

  bit_vector_engine_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .bit_pos(bit_pos), .bit_value(bit_value),
    .range_count(range_count), .word_select(word_select), .word_data(word_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .test_bit(test_bit), .bit_number(bit_number), .found(found), .last(last)
  );

  bit_vector_engine_checker checker_inst (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .bit_pos(bit_pos), .bit_value(bit_value),
    .range_count(range_count), .word_select(word_select), .word_data(word_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .test_bit(test_bit), .bit_number(bit_number), .found(found), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // count accepted input items and cycles
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) items_accepted <= items_accepted + 1;
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bit_vector_engine_top regression: fail");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    int hold_left;
    bit hold_taken;
    if (rst) begin
      out_ready = 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one item and wait for it to be taken
  task automatic send_req(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
                          input logic val, input logic [CNT_W-1:0] cnt,
                          input logic [SEL_W-1:0] sel, input logic [DATA_W-1:0] data);
    int taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    req_type = op;
    bit_pos = idx;
    bit_value = val;
    range_count = cnt;
    word_select = sel;
    word_data = data;
    in_valid = 1'b1;
    taken = items_accepted;
    do @(negedge clk); while (items_accepted == taken);
  endtask

  // random mix, weighted toward updates and enumeration with sparse data
  task automatic send_random(input int n);
    int r;
    logic [REQ_W-1:0]  op;
    logic [DATA_W-1:0] data;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 14) op = REQ_TEST;
      else if (r < 30) op = REQ_PUT_BIT;
      else if (r < 42) op = REQ_PUT_RANGE;
      else if (r < 49) op = REQ_CLEAR;
      else if (r < 61) op = REQ_OR_WORD;
      else if (r < 73) op = REQ_XOR_WORD;
      else if (r < 94) op = REQ_ENUM;
      else op = REQ_NOP;
      data = $urandom;
      if ($urandom_range(1)) data = data & $urandom & $urandom;
      send_req(op, IDX_W'($urandom_range(63)), 1'($urandom_range(1)),
               CNT_W'($urandom_range(127)), SEL_W'($urandom_range(1)), data);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_TEST;
    bit_pos = '0;
    bit_value = 1'b0;
    range_count = '0;
    word_select = '0;
    word_data = '0;
    hold_req = 1'b0;
    items_accepted = 0;
    cycle_count = 0;
    send_idle_pct = 17;
    recv_idle_pct = 79;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty vector, end bits, range edges, word merges, unused code
    send_req(REQ_ENUM, 0, 0, 0, 0, 32'h0);
    send_req(REQ_TEST, 0, 0, 0, 0, 32'h0);
    send_req(REQ_PUT_BIT, 63, 1, 0, 0, 32'h0);
    send_req(REQ_TEST, 63, 0, 0, 0, 32'h0);
    send_req(REQ_PUT_BIT, 0, 1, 0, 0, 32'h0);
    send_req(REQ_ENUM, 0, 0, 0, 0, 32'h0);
    send_req(REQ_PUT_BIT, 63, 0, 0, 0, 32'h0);
    send_req(REQ_PUT_RANGE, 0, 1, 0, 0, 32'h0);
    send_req(REQ_PUT_RANGE, 0, 1, 64, 0, 32'h0);
    send_req(REQ_ENUM, 0, 0, 0, 0, 32'h0);
    send_req(REQ_PUT_RANGE, 0, 0, 127, 0, 32'h0);
    send_req(REQ_OR_WORD, 0, 0, 0, 0, 32'hffff_ffff);
    send_req(REQ_XOR_WORD, 0, 0, 0, 1, 32'hffff_ffff);
    send_req(REQ_XOR_WORD, 0, 0, 0, 0, 32'ha5a5_a5a5);
    send_req(REQ_OR_WORD, 0, 0, 0, 1, 32'h0);
    send_req(REQ_TEST, 31, 0, 0, 0, 32'h0);
    send_req(REQ_TEST, 32, 0, 0, 0, 32'h0);
    send_req(REQ_PUT_RANGE, 0, 0, 33, 0, 32'h0);
    send_req(REQ_NOP, 63, 1, 127, 1, 32'hffff_ffff);
    send_req(REQ_ENUM, 0, 0, 0, 0, 32'h0);
    send_req(REQ_CLEAR, 0, 0, 0, 0, 32'h0);
    send_req(REQ_ENUM, 0, 0, 0, 0, 32'h0);
    send_req(REQ_PUT_BIT, 32, 1, 0, 0, 32'h0);
    send_req(REQ_TEST, 32, 0, 0, 0, 32'h0);

    // random: sender mostly busy, receiver mostly stalling
    send_random(140);

    // random: roles swapped
    send_idle_pct = 79;
    recv_idle_pct = 17;
    send_random(140);

    // random: no idling, with one long receiver hold-off to fill the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    send_random(130);
    in_valid = 1'b0;

    // drain
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("bit_vector_engine_top regression: pass");
    else
      $display("bit_vector_engine_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
design/bve_pkg.sv
design/bve_front.sv
design/bve_back.sv
design/bit_vector_engine_top.sv
sim/bit_vector_engine_checker.sv
sim/bit_vector_engine_top_tb.sv
